@@ sv/cmc_pkg.sv @@
`timescale 1ns / 1ps

package cmc_pkg;

  localparam int CH_BITS    = 16;
  localparam int ROW_BITS   = 48;
  localparam int SLOT_BITS  = 16;
  localparam int LEVEL_BITS = 7;
  localparam int DIV_BITS   = 8;
  localparam int NUM_BITS   = CH_BITS + DIV_BITS;
  localparam int MATRIX_FRAC = 8;

  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = CH_BITS / DIV_STAGES;

  // Product, sum, contrast front end, divider stages, output register.
  localparam int LATENCY = DIV_STAGES + 4;

  localparam logic [CH_BITS-1:0]  CH_MAX   = 16'hFFFF;
  localparam logic [DIV_BITS-1:0] DIV_BASE = 8'd255;

  localparam logic [ROW_BITS-1:0]   ROW_RESET_RED   = 48'h0000_0000_0100;
  localparam logic [ROW_BITS-1:0]   ROW_RESET_GREEN = 48'h0000_0100_0000;
  localparam logic [ROW_BITS-1:0]   ROW_RESET_BLUE  = 48'h0100_0000_0000;
  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET     = 7'd32;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MATRIX_EN   = 3'd0;
  localparam cfg_idx_t CFG_ROW_RED     = 3'd1;
  localparam cfg_idx_t CFG_ROW_GREEN   = 3'd2;
  localparam cfg_idx_t CFG_ROW_BLUE    = 3'd3;
  localparam cfg_idx_t CFG_CONTRAST_EN = 3'd4;
  localparam cfg_idx_t CFG_LEVEL       = 3'd5;

  typedef struct packed {
    logic [CH_BITS-1:0] red_in;
    logic [CH_BITS-1:0] green_in;
    logic [CH_BITS-1:0] blue_in;
  } cmc_pixel_in_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red_out;
    logic [CH_BITS-1:0] green_out;
    logic [CH_BITS-1:0] blue_out;
  } cmc_pixel_out_t;

  // Row 0 is red, row 1 green, row 2 blue.
  typedef struct packed {
    logic                       matrix_en;
    logic [2:0][ROW_BITS-1:0]   rows;
    logic                       contrast_en;
    logic [LEVEL_BITS-1:0]      level;
  } cmc_cfg_t;

  // One channel in the contrast divider. The dq field holds the dividend bits
  // still to be consumed at its top and the quotient bits produced at its bottom.
  typedef struct packed {
    logic                zero;
    logic                sat;
    logic [DIV_BITS-1:0] rem;
    logic [CH_BITS-1:0]  dq;
    logic [CH_BITS-1:0]  byp;
  } cmc_div_t;

  typedef cmc_div_t [2:0] cmc_div_lanes_t;

endpackage

@@ sv/cmc_config.sv @@
`timescale 1ns / 1ps

module cmc_config import cmc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_index,
  input  logic [ROW_BITS-1:0] cfg_data,
  output cmc_cfg_t            cfg_o
);

  cmc_cfg_t cfg_r;
  cmc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATRIX_EN:   cfg_nxt.matrix_en   = cfg_data[0];
        CFG_ROW_RED:     cfg_nxt.rows[0]     = cfg_data;
        CFG_ROW_GREEN:   cfg_nxt.rows[1]     = cfg_data;
        CFG_ROW_BLUE:    cfg_nxt.rows[2]     = cfg_data;
        CFG_CONTRAST_EN: cfg_nxt.contrast_en = cfg_data[0];
        CFG_LEVEL:       cfg_nxt.level       = cfg_data[LEVEL_BITS-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.matrix_en   <= 1'b0;
      cfg_r.rows[0]     <= ROW_RESET_RED;
      cfg_r.rows[1]     <= ROW_RESET_GREEN;
      cfg_r.rows[2]     <= ROW_RESET_BLUE;
      cfg_r.contrast_en <= 1'b0;
      cfg_r.level       <= LEVEL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

`ifndef SYNTH
  a_level_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_LEVEL) |=> cfg_r.level == $past(cfg_data[LEVEL_BITS-1:0]))
    else $error("contrast level register did not take the written word");
`endif

endmodule

@@ sv/cmc_matrix.sv @@
`timescale 1ns / 1ps

module cmc_matrix import cmc_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int COEF_BITS  = 16,
  parameter int VAL_BITS   = 25
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmc_cfg_t                 cfg,
  input  logic                     in_valid,
  input  cmc_pixel_in_t            in_pixel,
  output logic                     out_valid,
  output logic [2:0][VAL_BITS-1:0] out_val
);

  localparam int PROD_BITS = PIXEL_BITS + COEF_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;

  logic [2:0][PIXEL_BITS-1:0]   pix;
  logic signed [PROD_BITS-1:0]  prod_nxt [3][3];
  logic signed [PROD_BITS-1:0]  prod_r   [3][3];
  logic [2:0][PIXEL_BITS-1:0]   pix_r;
  logic                         prod_valid_r;
  logic signed [SUM_BITS-1:0]   sum [3];
  logic [2:0][VAL_BITS-1:0]     val_nxt;
  logic [2:0][VAL_BITS-1:0]     val_r;
  logic                         val_valid_r;

  // Stage 1: nine signed products of the pixel and the Q8 coefficients.
  always_comb begin
    logic signed [COEF_BITS-1:0] coef;
    pix[0] = in_pixel.red_in[PIXEL_BITS-1:0];
    pix[1] = in_pixel.green_in[PIXEL_BITS-1:0];
    pix[2] = in_pixel.blue_in[PIXEL_BITS-1:0];
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        coef = $signed(cfg.rows[c][SLOT_BITS*k +: COEF_BITS]);
        prod_nxt[c][k] = $signed({1'b0, pix[k]}) * coef;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    pix_r  <= pix;
  end

  // Stage 2: row sums, clamp at zero, drop fraction bits; bypass if matrix is off.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SUM_BITS'(prod_r[c][0]) + SUM_BITS'(prod_r[c][1]) + SUM_BITS'(prod_r[c][2]);
      if (!cfg.matrix_en) begin
        val_nxt[c] = VAL_BITS'(pix_r[c]);
      end else if (sum[c][SUM_BITS-1]) begin
        val_nxt[c] = '0;
      end else begin
        val_nxt[c] = VAL_BITS'(sum[c][SUM_BITS-2:MATRIX_FRAC]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_valid_r <= 1'b0;
    end else begin
      val_valid_r <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign out_valid = val_valid_r;
  assign out_val   = val_r;

endmodule

@@ sv/cmc_div_stage.sv @@
`timescale 1ns / 1ps

module cmc_div_stage import cmc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [DIV_BITS-1:0] divisor,
  input  logic                in_valid,
  input  cmc_div_lanes_t      in_lanes,
  output logic                out_valid,
  output cmc_div_lanes_t      out_lanes
);

  cmc_div_lanes_t lanes_nxt;
  cmc_div_lanes_t lanes_r;
  logic           valid_r;

  // Restoring division, DIV_STEPS quotient bits per stage. The remainder stays
  // below the divisor, so the trial value needs only one extra bit.
  always_comb begin
    logic [DIV_BITS:0] trial;
    lanes_nxt = in_lanes;
    for (int c = 0; c < 3; c++) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial = {lanes_nxt[c].rem, lanes_nxt[c].dq[CH_BITS-1]};
        if (trial >= {1'b0, divisor}) begin
          trial = trial - {1'b0, divisor};
          lanes_nxt[c].dq = {lanes_nxt[c].dq[CH_BITS-2:0], 1'b1};
        end else begin
          lanes_nxt[c].dq = {lanes_nxt[c].dq[CH_BITS-2:0], 1'b0};
        end
        lanes_nxt[c].rem = trial[DIV_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
  end

  assign out_valid = valid_r;
  assign out_lanes = lanes_r;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |->
      (lanes_r[0].zero || lanes_r[0].sat || lanes_r[0].rem < divisor) &&
      (lanes_r[1].zero || lanes_r[1].sat || lanes_r[1].rem < divisor) &&
      (lanes_r[2].zero || lanes_r[2].sat || lanes_r[2].rem < divisor))
    else $error("divider remainder reached the divisor");
`endif

endmodule

@@ sv/cmc_contrast.sv @@
`timescale 1ns / 1ps

module cmc_contrast import cmc_pkg::*; #(
  parameter int VAL_BITS = 25
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmc_cfg_t                 cfg,
  input  logic                     in_valid,
  input  logic [2:0][VAL_BITS-1:0] in_val,
  output logic                     out_valid,
  output cmc_pixel_out_t           out_pixel
);

  logic [DIV_BITS-1:0]  divisor;
  logic [VAL_BITS-1:0]  black;
  cmc_div_lanes_t       front_nxt;
  cmc_div_lanes_t       front_r;
  logic                 front_valid_r;
  cmc_div_lanes_t       lanes      [DIV_STAGES+1];
  logic                 lane_valid [DIV_STAGES+1];
  logic [2:0][CH_BITS-1:0] res;
  cmc_pixel_out_t       out_nxt;
  cmc_pixel_out_t       out_r;
  logic                 out_valid_r;

  assign divisor = DIV_BASE - {cfg.level, 1'b0};
  assign black   = VAL_BITS'({cfg.level, 8'h00});

  // Front end: subtract the black point and scale by 255. When the offset is
  // 2^16 or more the quotient is at least as large, so it saturates at once;
  // otherwise the dividend fits in 24 bits and the quotient in 16 bits
  // unless the saturation compare says so.
  always_comb begin
    logic [VAL_BITS-1:0] diff;
    logic [CH_BITS-1:0]  low;
    logic [NUM_BITS-1:0] scaled;
    for (int c = 0; c < 3; c++) begin
      diff   = in_val[c] - black;
      low    = diff[CH_BITS-1:0];
      scaled = {low, 8'h00} - {8'h00, low};
      front_nxt[c].zero = in_val[c] <= black;
      front_nxt[c].sat  = (|diff[VAL_BITS-1:CH_BITS]) || (scaled >= {divisor, 16'h0000});
      front_nxt[c].rem  = scaled[NUM_BITS-1:CH_BITS];
      front_nxt[c].dq   = scaled[CH_BITS-1:0];
      front_nxt[c].byp  = (|in_val[c][VAL_BITS-1:CH_BITS]) ? CH_MAX : in_val[c][CH_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
  end

  assign lanes[0]      = front_r;
  assign lane_valid[0] = front_valid_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    cmc_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (divisor),
      .in_valid  (lane_valid[g]),
      .in_lanes  (lanes[g]),
      .out_valid (lane_valid[g+1]),
      .out_lanes (lanes[g+1])
    );
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      priority if (!cfg.contrast_en) begin
        res[c] = lanes[DIV_STAGES][c].byp;
      end else if (lanes[DIV_STAGES][c].zero) begin
        res[c] = '0;
      end else if (lanes[DIV_STAGES][c].sat) begin
        res[c] = CH_MAX;
      end else begin
        res[c] = lanes[DIV_STAGES][c].dq;
      end
    end
    out_nxt.red_out   = res[0];
    out_nxt.green_out = res[1];
    out_nxt.blue_out  = res[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= lane_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_r;

endmodule

@@ sv/color_matrix_contrast.sv @@
`timescale 1ns / 1ps

// Channel   Ports                                         Handshake
// input     start, busy, in_pixel                         word taken when start && !busy
// result    out_valid, out_pixel                          one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data     write when valid && ready
//
// One pixel may enter every clock cycle while busy is low; each word passes through the
// product, sum and front-end stages, the four divider stages of the contrast stretch and
// the output register.
// busy is high and cfg_ready low while reset holds busy_r set and until busy_r clears
// after reset; from then on the pipeline never stalls, so the receiver must take every
// result in the cycle it is shown; the block itself does not enforce this.
module color_matrix_contrast import cmc_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cmc_pixel_in_t       in_pixel,
  output logic                out_valid,
  output cmc_pixel_out_t      out_pixel,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cfg_idx_t            cfg_index,
  input  logic [ROW_BITS-1:0] cfg_data
);

  localparam int VAL_BITS = (PIXEL_BITS + COEF_BITS + 1 - MATRIX_FRAC > CH_BITS + 1) ?
                            PIXEL_BITS + COEF_BITS + 1 - MATRIX_FRAC : CH_BITS + 1;

  logic                     busy_r;
  logic                     accept;
  cmc_cfg_t                 cfg;
  logic                     mat_valid;
  logic [2:0][VAL_BITS-1:0] mat_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign accept    = start && !busy_r;

  cmc_config u_config (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  cmc_matrix #(
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS),
    .VAL_BITS   (VAL_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (accept),
    .in_pixel  (in_pixel),
    .out_valid (mat_valid),
    .out_val   (mat_val)
  );

  cmc_contrast #(
    .VAL_BITS (VAL_BITS)
  ) u_contrast (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (mat_valid),
    .in_val    (mat_val),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

`ifndef SYNTH
  a_word_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("accepted word did not come out after the pipeline latency");

  a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted word");
`endif

endmodule
